// ----- rtl/longest_prefix_match_trie_defines.svh -----
// Assertion macros used by the trie datapath.
`ifndef LONGEST_PREFIX_MATCH_TRIE_DEFINES_SVH
`define LONGEST_PREFIX_MATCH_TRIE_DEFINES_SVH

`ifndef SYNTHESIS
`define LPMT_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lpmt assertion failed");
`define LPMT_ASSERT_MSG(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);
`else
`define LPMT_ASSERT(name, clk, rst, prop)
`define LPMT_ASSERT_MSG(name, clk, rst, prop, msg)
`endif

`endif

// ----- rtl/lpmt_pkg.sv -----
// Shared types and constants for the longest-prefix-match trie.
package lpmt_pkg;

   localparam int MODE_W  = 2;
   localparam int LABEL_W = 32;
   localparam int LEN_W   = 6;
   localparam int COUNT_W = 11;

   localparam logic [LABEL_W-1:0] NO_LABEL = '1;

   typedef enum logic [MODE_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic start;
      logic step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/lpmt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lpmt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- rtl/lpmt_ctrl.sv -----
// Controller state machine sequencing accept, trie walk and result hand-off.
module lpmt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lpmt_pkg::status_type   sts,
   output lpmt_pkg::cmd_type      cmd
);
   import lpmt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (sts.done) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.start    = 1'b0;
      cmd.step     = 1'b0;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         ST_WALK: begin
            cmd.step = 1'b1;
         end
         ST_OUTPUT: begin
            cmd.load_out = sts.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ----- rtl/lpmt_datapath.sv -----
// Trie datapath: node memories, root node, walk registers and result register.
`include "longest_prefix_match_trie_defines.svh"
module lpmt_datapath #(
   parameter int NODE_POOL = 1024,
   parameter int ADDR_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lpmt_pkg::cmd_type              cmd,
   output lpmt_pkg::status_type           sts,
   input  logic [lpmt_pkg::MODE_W-1:0]    req_mode,
   input  logic [31:0]                    req_address,
   input  logic [lpmt_pkg::LEN_W-1:0]     req_prefix_length,
   input  logic signed [lpmt_pkg::LABEL_W-1:0] req_route_label,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_matched,
   output logic signed [lpmt_pkg::LABEL_W-1:0] rsp_match_label,
   output logic                           rsp_success,
   output logic                           rsp_pool_full,
   output logic [lpmt_pkg::COUNT_W-1:0]   rsp_prefix_count
);
   import lpmt_pkg::*;

   localparam int IW = $clog2(NODE_POOL);
   localparam int CW = $clog2(NODE_POOL + 1);
   localparam int DW = $clog2(ADDR_BITS + 1);
   localparam int EW = 2 * IW + 1;

   mode_type               op_ff;
   logic [ADDR_BITS-1:0]   addr_ff, addr_in;
   logic [DW-1:0]          len_ff, len_in;
   logic [DW-1:0]          depth_ff, depth_in;
   logic [LABEL_W-1:0]     label_ff;
   logic [IW-1:0]          node_ff, node_in;
   logic                   root_ff, root_in;
   logic                   fresh_ff, fresh_in;
   logic                   best_valid_ff, best_valid_in;
   logic [IW-1:0]          best_ff, best_in;
   logic [CW-1:0]          nodes_used_ff, nodes_used_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   success_ff, success_in;
   logic                   full_ff, full_in;
   logic [IW-1:0]          root_c0_ff, root_c1_ff;
   logic                   root_mark_ff;
   logic [LABEL_W-1:0]     root_label_ff;
   logic                   rsp_valid_ff;

   logic [EW-1:0]          ent_rd;
   logic [LABEL_W-1:0]     lab_rd;
   logic [IW-1:0]          cur_c0, cur_c1, child, new_node;
   logic                   cur_mark, bit_sel, at_len, at_top, pool_out;
   logic                   step_done, descend;
   logic                   ent_wr, lab_wr;
   logic [EW-1:0]          ent_wr_data;

   assign cur_c0   = root_ff ? root_c0_ff   : (fresh_ff ? '0   : ent_rd[EW-1 -: IW]);
   assign cur_c1   = root_ff ? root_c1_ff   : (fresh_ff ? '0   : ent_rd[IW:1]);
   assign cur_mark = root_ff ? root_mark_ff : (fresh_ff ? 1'b0 : ent_rd[0]);
   assign bit_sel  = addr_ff[ADDR_BITS-1];
   assign child    = bit_sel ? cur_c1 : cur_c0;
   assign at_len   = (depth_ff == len_ff);
   assign at_top   = (depth_ff == DW'(ADDR_BITS));
   assign pool_out = (nodes_used_ff == CW'(NODE_POOL));
   assign new_node = nodes_used_ff[IW-1:0];

   assign len_in = (req_prefix_length > LEN_W'(ADDR_BITS)) ? DW'(ADDR_BITS)
                                                          : DW'(req_prefix_length);

   always_comb begin
      addr_in       = addr_ff;
      depth_in      = depth_ff;
      node_in       = node_ff;
      root_in       = root_ff;
      fresh_in      = fresh_ff;
      best_valid_in = best_valid_ff;
      best_in       = best_ff;
      nodes_used_in = nodes_used_ff;
      count_in      = count_ff;
      success_in    = success_ff;
      full_in       = full_ff;
      step_done     = 1'b0;
      descend       = 1'b0;
      ent_wr        = 1'b0;
      ent_wr_data   = {cur_c0, cur_c1, cur_mark};
      lab_wr        = 1'b0;
      if (cmd.start) begin
         addr_in       = req_address[ADDR_BITS-1:0];
         depth_in      = '0;
         node_in       = '0;
         root_in       = 1'b1;
         fresh_in      = 1'b0;
         best_valid_in = 1'b0;
         best_in       = '0;
         success_in    = 1'b0;
         full_in       = 1'b0;
      end else if (cmd.step) begin
         unique case (op_ff)
            OP_INSERT: begin
               if (at_len) begin
                  step_done   = 1'b1;
                  ent_wr      = 1'b1;
                  ent_wr_data = {cur_c0, cur_c1, 1'b1};
                  lab_wr      = 1'b1;
                  success_in  = 1'b1;
                  if (!cur_mark) begin
                     count_in = count_ff + CW'(1);
                  end
               end else if (child == '0) begin
                  if (pool_out) begin
                     step_done = 1'b1;
                     full_in   = 1'b1;
                     ent_wr    = fresh_ff;
                  end else begin
                     ent_wr        = 1'b1;
                     ent_wr_data   = bit_sel ? {cur_c0, new_node, cur_mark}
                                             : {new_node, cur_c1, cur_mark};
                     nodes_used_in = nodes_used_ff + CW'(1);
                     addr_in       = addr_ff << 1;
                     depth_in      = depth_ff + DW'(1);
                     node_in       = new_node;
                     root_in       = 1'b0;
                     fresh_in      = 1'b1;
                  end
               end else begin
                  descend = 1'b1;
               end
            end
            OP_REMOVE: begin
               if (at_len) begin
                  step_done = 1'b1;
                  if (cur_mark) begin
                     ent_wr      = 1'b1;
                     ent_wr_data = {cur_c0, cur_c1, 1'b0};
                     success_in  = 1'b1;
                     if (count_ff != '0) begin
                        count_in = count_ff - CW'(1);
                     end
                  end
               end else if (child == '0) begin
                  step_done = 1'b1;
               end else begin
                  descend = 1'b1;
               end
            end
            OP_LOOKUP: begin
               if (cur_mark) begin
                  best_valid_in = 1'b1;
                  best_in       = node_ff;
               end
               if (at_top || child == '0) begin
                  step_done = 1'b1;
               end else begin
                  descend = 1'b1;
               end
            end
            default: begin
               step_done = 1'b1;
            end
         endcase
         if (descend) begin
            addr_in  = addr_ff << 1;
            depth_in = depth_ff + DW'(1);
            node_in  = child;
            root_in  = 1'b0;
            fresh_in = 1'b0;
         end
      end
   end

   lpmt_ram #(
      .WIDTH (EW),
      .DEPTH (NODE_POOL)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ent_wr && !root_ff),
      .wr_addr (node_ff),
      .wr_data (ent_wr_data),
      .rd_addr (child),
      .rd_data (ent_rd)
   );

   lpmt_ram #(
      .WIDTH (LABEL_W),
      .DEPTH (NODE_POOL)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (lab_wr && !root_ff),
      .wr_addr (node_ff),
      .wr_data (label_ff),
      .rd_addr (best_in),
      .rd_data (lab_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff       <= 1'b1;
         fresh_ff      <= 1'b0;
         best_valid_ff <= 1'b0;
         nodes_used_ff <= CW'(1);
         count_ff      <= '0;
         root_c0_ff    <= '0;
         root_c1_ff    <= '0;
         root_mark_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         root_ff       <= root_in;
         fresh_ff      <= fresh_in;
         best_valid_ff <= best_valid_in;
         nodes_used_ff <= nodes_used_in;
         count_ff      <= count_in;
         if (ent_wr && root_ff) begin
            root_c0_ff   <= ent_wr_data[EW-1 -: IW];
            root_c1_ff   <= ent_wr_data[IW:1];
            root_mark_ff <= ent_wr_data[0];
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      depth_ff   <= depth_in;
      node_ff    <= node_in;
      best_ff    <= best_in;
      success_ff <= success_in;
      full_ff    <= full_in;
      if (cmd.start) begin
         op_ff    <= mode_type'(req_mode);
         len_ff   <= len_in;
         label_ff <= req_route_label;
      end
      if (lab_wr && root_ff) begin
         root_label_ff <= label_ff;
      end
      if (cmd.load_out) begin
         rsp_matched      <= best_valid_ff;
         rsp_match_label  <= !best_valid_ff ? NO_LABEL
                           : (best_ff == '0) ? root_label_ff : lab_rd;
         rsp_success      <= success_ff;
         rsp_pool_full    <= full_ff;
         rsp_prefix_count <= COUNT_W'(count_ff);
      end
   end

   assign sts.done     = step_done;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;

   `LPMT_ASSERT(a_pool_bounds, clock, reset,
      (nodes_used_ff != '0) && (nodes_used_ff <= CW'(NODE_POOL)))
   `LPMT_ASSERT_MSG(a_count_le_nodes, clock, reset,
      count_ff <= nodes_used_ff, "more stored prefixes than allocated nodes")
   `LPMT_ASSERT(a_fresh_not_root, clock, reset, fresh_ff |-> !root_ff)
   `LPMT_ASSERT_MSG(a_alloc_fresh, clock, reset,
      ((nodes_used_ff != $past(nodes_used_ff)) && !$past(reset)) |-> fresh_ff,
      "node allocated without moving to the new node")
   `LPMT_ASSERT(a_best_lookup_only, clock, reset,
      best_valid_ff |-> (op_ff == OP_LOOKUP))

endmodule

// ----- rtl/longest_prefix_match_trie.sv -----
// Top level of the binary-trie IPv4 longest-prefix-match engine.
// Each item is accepted, then walked down the trie with one node read per level, to at most
// L levels (L = prefix length, or ADDR_BITS for lookup), and then its result is loaded.
// One item at a time: no new request is taken while the walk runs or a result waits.
// Reset clears the root node, the node and prefix counters and the result valid.
// No clearing pass: nodes are allocated in order and written before they are first read.
module longest_prefix_match_trie #(
   parameter int NODE_POOL = 1024,
   parameter int ADDR_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lpmt_pkg::MODE_W-1:0]          req_mode,
   input  logic [31:0]                          req_address,
   input  logic [lpmt_pkg::LEN_W-1:0]           req_prefix_length,
   input  logic signed [lpmt_pkg::LABEL_W-1:0]  req_route_label,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_matched,
   output logic signed [lpmt_pkg::LABEL_W-1:0]  rsp_match_label,
   output logic                                 rsp_success,
   output logic                                 rsp_pool_full,
   output logic [lpmt_pkg::COUNT_W-1:0]         rsp_prefix_count
);
   import lpmt_pkg::*;

   cmd_type    cmd;
   status_type sts;

   lpmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lpmt_datapath #(
      .NODE_POOL (NODE_POOL),
      .ADDR_BITS (ADDR_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_mode          (req_mode),
      .req_address       (req_address),
      .req_prefix_length (req_prefix_length),
      .req_route_label   (req_route_label),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_matched       (rsp_matched),
      .rsp_match_label   (rsp_match_label),
      .rsp_success       (rsp_success),
      .rsp_pool_full     (rsp_pool_full),
      .rsp_prefix_count  (rsp_prefix_count)
   );

endmodule

// ----- test/longest_prefix_match_trie_checker.sv -----
// Response checker for the trie: predicts each result from the accepted requests and compares.
`timescale 1ns / 100ps
module longest_prefix_match_trie_checker #(
   parameter int NODE_POOL = 1024,
   parameter int ADDR_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [lpmt_pkg::MODE_W-1:0]          req_mode,
   input  logic [31:0]                          req_address,
   input  logic [lpmt_pkg::LEN_W-1:0]           req_prefix_length,
   input  logic signed [lpmt_pkg::LABEL_W-1:0]  req_route_label,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic                                 rsp_matched,
   input  logic signed [lpmt_pkg::LABEL_W-1:0]  rsp_match_label,
   input  logic                                 rsp_success,
   input  logic                                 rsp_pool_full,
   input  logic [lpmt_pkg::COUNT_W-1:0]         rsp_prefix_count,
   output int                                   mismatch_count,
   output int                                   results_pending
);

   typedef struct packed {
      logic                          matched;
      logic [lpmt_pkg::LABEL_W-1:0]  label;
      logic                          success;
      logic                          pool_full;
      logic [lpmt_pkg::COUNT_W-1:0]  count;
   } route_result_type;

   int unsigned                   branch_zero [NODE_POOL];
   int unsigned                   branch_one [NODE_POOL];
   bit                            is_prefix [NODE_POOL];
   logic [lpmt_pkg::LABEL_W-1:0]  stored_label [NODE_POOL];
   int unsigned                   nodes_taken;
   int unsigned                   prefix_total;
   int unsigned                   node_ix;
   int unsigned                   responses_seen;
   route_result_type              results_due [$];
   route_result_type              due;

   initial begin
      mismatch_count = 0;
      results_pending = 0;
      responses_seen = 0;
   end

   function automatic route_result_type predict_route(
      input logic [lpmt_pkg::MODE_W-1:0]   mode,
      input logic [31:0]                   addr,
      input logic [lpmt_pkg::LEN_W-1:0]    len_in,
      input logic [lpmt_pkg::LABEL_W-1:0]  label
   );
      route_result_type res;
      int unsigned   node;
      int unsigned   next;
      int unsigned   len;
      int unsigned   depth;
      bit            path_ok;
      bit            bit_val;

      res.matched = 1'b0;
      res.label = lpmt_pkg::NO_LABEL;
      res.success = 1'b0;
      res.pool_full = 1'b0;
      node = 0;
      path_ok = 1'b1;
      len = (len_in > ADDR_BITS) ? ADDR_BITS : len_in;

      case (mode)
         lpmt_pkg::OP_INSERT: begin
            for (depth = 0; depth < len && path_ok; depth++) begin
               bit_val = addr[ADDR_BITS-1-depth];
               next = bit_val ? branch_one[node] : branch_zero[node];
               if (next == 0 && nodes_taken >= NODE_POOL) begin
                  path_ok = 1'b0;
               end else begin
                  if (next == 0) begin
                     next = nodes_taken;
                     nodes_taken++;
                     branch_zero[next] = 0;
                     branch_one[next] = 0;
                     is_prefix[next] = 1'b0;
                     if (bit_val) branch_one[node] = next;
                     else branch_zero[node] = next;
                  end
                  node = next;
               end
            end
            if (path_ok) begin
               if (!is_prefix[node]) prefix_total++;
               is_prefix[node] = 1'b1;
               stored_label[node] = label;
               res.success = 1'b1;
            end else begin
               res.pool_full = 1'b1;
            end
         end
         lpmt_pkg::OP_REMOVE: begin
            for (depth = 0; depth < len && path_ok; depth++) begin
               next = addr[ADDR_BITS-1-depth] ? branch_one[node] : branch_zero[node];
               if (next == 0) path_ok = 1'b0;
               else node = next;
            end
            if (path_ok && is_prefix[node]) begin
               is_prefix[node] = 1'b0;
               stored_label[node] = lpmt_pkg::NO_LABEL;
               if (prefix_total > 0) prefix_total--;
               res.success = 1'b1;
            end
         end
         lpmt_pkg::OP_LOOKUP: begin
            if (is_prefix[0]) begin
               res.matched = 1'b1;
               res.label = stored_label[0];
            end
            for (depth = 0; depth < ADDR_BITS && path_ok; depth++) begin
               next = addr[ADDR_BITS-1-depth] ? branch_one[node] : branch_zero[node];
               if (next == 0) begin
                  path_ok = 1'b0;
               end else begin
                  node = next;
                  if (is_prefix[node]) begin
                     res.matched = 1'b1;
                     res.label = stored_label[node];
                  end
               end
            end
         end
         default: begin
         end
      endcase
      res.count = prefix_total[lpmt_pkg::COUNT_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: trie response %0d: %s", $realtime, responses_seen, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (node_ix = 0; node_ix < NODE_POOL; node_ix++) begin
            branch_zero[node_ix] = 0;
            branch_one[node_ix] = 0;
            is_prefix[node_ix] = 1'b0;
            stored_label[node_ix] = '0;
         end
         nodes_taken = 1;
         prefix_total = 0;
         results_due.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_ready) begin
            responses_seen++;
            if (results_due.size() == 0) begin
               report_mismatch("response arrived with no request outstanding");
            end else begin
               due = results_due.pop_front();
               check_field("matched", rsp_matched, due.matched);
               check_field("match_label", rsp_match_label, due.label);
               check_field("success", rsp_success, due.success);
               check_field("pool_full", rsp_pool_full, due.pool_full);
               check_field("prefix_count", rsp_prefix_count, due.count);
            end
         end
         if (req_valid && req_ready === 1'b1)
            results_due.push_back(predict_route(req_mode, req_address,
                                                req_prefix_length, req_route_label));
      end
      results_pending = results_due.size();
   end

endmodule

// ----- test/longest_prefix_match_trie_tb.sv -----
// Testbench top for the trie: clock, reset, request stimulus, response flow control and verdict.
`timescale 1ns / 100ps
module longest_prefix_match_trie_tb;

   localparam logic [lpmt_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int BASE_COUNT   = 12;
   localparam int LIVE_MAX     = 32;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic [lpmt_pkg::MODE_W-1:0]          req_mode = '0;
   logic [31:0]                          req_address = '0;
   logic [lpmt_pkg::LEN_W-1:0]           req_prefix_length = '0;
   logic signed [lpmt_pkg::LABEL_W-1:0]  req_route_label = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic                                 rsp_matched;
   logic signed [lpmt_pkg::LABEL_W-1:0]  rsp_match_label;
   logic                                 rsp_success;
   logic                                 rsp_pool_full;
   logic [lpmt_pkg::COUNT_W-1:0]         rsp_prefix_count;

   int          mismatch_count;
   int          results_pending;
   int          cycle_count = 0;
   int          send_idle_pct = 30;
   int          rsp_idle_pct = 68;
   int          holds_asked = 0;
   logic [31:0] route_base [BASE_COUNT];
   logic [31:0] live_addr [$];
   logic [5:0]  live_len [$];

   longest_prefix_match_trie u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_address       (req_address),
      .req_prefix_length (req_prefix_length),
      .req_route_label   (req_route_label),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_matched       (rsp_matched),
      .rsp_match_label   (rsp_match_label),
      .rsp_success       (rsp_success),
      .rsp_pool_full     (rsp_pool_full),
      .rsp_prefix_count  (rsp_prefix_count)
   );

   longest_prefix_match_trie_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_address       (req_address),
      .req_prefix_length (req_prefix_length),
      .req_route_label   (req_route_label),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_matched       (rsp_matched),
      .rsp_match_label   (rsp_match_label),
      .rsp_success       (rsp_success),
      .rsp_pool_full     (rsp_pool_full),
      .rsp_prefix_count  (rsp_prefix_count),
      .mismatch_count    (mismatch_count),
      .results_pending   (results_pending)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("longest_prefix_match_trie_tb NOT OK");
         $finish;
      end
   end

   initial begin : response_sink
      int hold_left;
      int holds_done;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (holds_asked > holds_done) begin
            holds_done++;
            hold_left = LONG_HOLD;
            while (hold_left > 0) begin
               rsp_ready <= 1'b0;
               hold_left--;
               @(posedge clock);
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic send_request(input logic [1:0] mode, input logic [31:0] addr,
                               input logic [5:0] len, input logic [31:0] label);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_address <= addr;
      req_prefix_length <= len;
      req_route_label <= label;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (results_pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic random_request();
      int          pick;
      int          ix;
      logic [31:0] addr;
      logic [31:0] flip;
      logic [5:0]  len;
      logic [1:0]  mode;

      pick = $urandom_range(99);
      flip = $urandom >> $urandom_range(32, 12);
      if ($urandom_range(9) == 0) addr = $urandom;
      else addr = route_base[$urandom_range(BASE_COUNT-1)] ^ flip;
      case ($urandom_range(19))
         0, 1: len = 6'($urandom_range(63, 33));
         2, 3, 4: len = 6'd32;
         default: len = 6'($urandom_range(32));
      endcase
      if (pick < 3) begin
         mode = MODE_UNUSED;
         len = 6'($urandom);
      end else if (pick < 38) begin
         mode = lpmt_pkg::OP_INSERT;
         live_addr.push_back(addr);
         live_len.push_back(len);
         if (live_addr.size() > LIVE_MAX) begin
            void'(live_addr.pop_front());
            void'(live_len.pop_front());
         end
      end else if (pick < 56) begin
         mode = lpmt_pkg::OP_REMOVE;
         if (live_addr.size() != 0 && $urandom_range(9) < 7) begin
            ix = $urandom_range(live_addr.size() - 1);
            addr = live_addr[ix];
            len = live_len[ix];
            live_addr.delete(ix);
            live_len.delete(ix);
         end
      end else begin
         mode = lpmt_pkg::OP_LOOKUP;
      end
      send_request(mode, addr, len, $urandom);
   endtask

   task automatic run_random(input int count);
      repeat (count) random_request();
   endtask

   initial begin
      for (int b = 0; b < BASE_COUNT; b++) route_base[b] = $urandom;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Empty table, root prefix, clamped lengths, label extremes, reinsert and removes.
      send_request(lpmt_pkg::OP_LOOKUP, 32'h0000_0000, 6'd0, 32'h0);
      send_request(lpmt_pkg::OP_REMOVE, 32'h0A00_0000, 6'd8, 32'h0);
      send_request(lpmt_pkg::OP_INSERT, 32'h1234_5678, 6'd0, 32'h7FFF_FFFF);
      send_request(lpmt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 32'h0);
      send_request(lpmt_pkg::OP_INSERT, 32'h0A00_0000, 6'd8, 32'h8000_0000);
      send_request(lpmt_pkg::OP_INSERT, 32'h0A01_0000, 6'd16, 32'hFFFF_FFFF);
      send_request(lpmt_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd32, 32'h0000_0000);
      send_request(lpmt_pkg::OP_INSERT, 32'h0000_0000, 6'd63, 32'h0000_0005);
      send_request(lpmt_pkg::OP_LOOKUP, 32'h0A01_0203, 6'd0, 32'h0);
      send_request(lpmt_pkg::OP_LOOKUP, 32'h0A02_0000, 6'd0, 32'h0);
      send_request(lpmt_pkg::OP_LOOKUP, 32'h0000_0000, 6'd32, 32'h0);
      send_request(lpmt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0);
      send_request(lpmt_pkg::OP_INSERT, 32'h0AFF_FFFF, 6'd8, 32'd123);
      send_request(lpmt_pkg::OP_LOOKUP, 32'h0A09_0909, 6'd0, 32'h0);
      send_request(lpmt_pkg::OP_REMOVE, 32'h0A01_0000, 6'd16, 32'h0);
      send_request(lpmt_pkg::OP_REMOVE, 32'h0A01_0000, 6'd16, 32'h0);
      send_request(lpmt_pkg::OP_LOOKUP, 32'h0A01_0203, 6'd0, 32'h0);
      send_request(MODE_UNUSED, 32'hDEAD_BEEF, 6'd12, 32'h5555_AAAA);
      send_request(lpmt_pkg::OP_REMOVE, 32'h8765_4321, 6'd0, 32'h0);
      send_request(lpmt_pkg::OP_LOOKUP, 32'h1234_5678, 6'd0, 32'h0);
      send_request(lpmt_pkg::OP_REMOVE, 32'hFFFF_FFFF, 6'd40, 32'h0);
      send_request(lpmt_pkg::OP_INSERT, 32'hAAAA_AAAA, 6'd1, 32'hC001_D00D);
      send_request(lpmt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0);
      wait_drained();

      run_random(500);
      wait_drained();

      send_idle_pct = 68;
      rsp_idle_pct = 30;
      run_random(500);
      wait_drained();

      send_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(100);
      holds_asked++;
      run_random(100);
      wait_drained();
      run_random(280);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("longest_prefix_match_trie_tb OK");
      end else begin
         $display("longest_prefix_match_trie_tb NOT OK");
      end
      $finish;
   end

endmodule
